FILE: design/sample_table_poke_and_centroid_assert.svh
// ----------------------------------------------------------------------------
// Sample table poke and centroid: assertion macros
// Concurrent assertion shorthands used by the checker in stpc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_TABLE_POKE_AND_CENTROID_ASSERT_SVH
`define SAMPLE_TABLE_POKE_AND_CENTROID_ASSERT_SVH

// Property checked outside reset.
`define STPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that also covers the reset cycles.
`define STPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/stpc_pkg.sv
// ----------------------------------------------------------------------------
// stpc_pkg
// Types, constants and helpers of the sample table poke and centroid block.
// ----------------------------------------------------------------------------
package stpc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int CFG_W       = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
  localparam int SAMPLE_W    = 16;
  localparam int SPAN_W      = 16;
  localparam int CEN_W       = 32;
  localparam int FRAC_W      = 8;
  // sum of i*s over the table, and sum of s
  localparam int TOP_W       = SAMPLE_W + 2 * IDX_W + 1;
  localparam int BOT_W       = SAMPLE_W + IDX_W + 1;
  // quotient magnitude bits and step counter of the divider
  localparam int DIV_W       = TOP_W + FRAC_W;
  localparam int DIV_CNT_W   = $clog2(DIV_W + 1);
  localparam logic [CEN_W-1:0] CEN_MAX = {1'b0, {(CEN_W-1){1'b1}}};
  localparam logic [CEN_W-1:0] CEN_MIN = {1'b1, {(CEN_W-1){1'b0}}};

  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic KIND_SAMPLE   = 1'b0;
  localparam logic KIND_CENTROID = 1'b1;

  typedef enum logic [1:0] {
    REQ_ARM      = 2'd0,
    REQ_ACCESS   = 2'd1,
    REQ_WRITE    = 2'd2,
    REQ_CENTROID = 2'd3
  } stpc_req_t;

  typedef struct packed {
    stpc_req_t                   req_type;
    logic signed [31:0]          index;
    logic signed [SAMPLE_W-1:0]  sample_in;
    logic [SPAN_W-1:0]           span_length;
  } stpc_in_t;

  typedef struct packed {
    logic                        result_kind;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic signed [CEN_W-1:0]     centroid_out;
  } stpc_out_t;

  // classified request as it travels through the queue
  typedef struct packed {
    stpc_req_t                   req;
    logic [IDX_W-1:0]            idx;
    logic signed [SAMPLE_W-1:0]  sample;
    logic [SIZE_W-1:0]           span;
  } stpc_op_t;

  typedef struct packed {
    logic     push;
    stpc_op_t op;
  } stpc_push_t;

  typedef struct packed {
    logic     avail;
    stpc_op_t op;
  } stpc_head_t;

  typedef struct packed {
    logic                     start;
    logic signed [TOP_W-1:0]  num;
    logic signed [BOT_W-1:0]  den;
  } stpc_div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [CEN_W-1:0]  quo;
  } stpc_div_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_RESP
  } stpc_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_RUN,
    DV_FIN
  } stpc_div_state_t;

  // table size in use: 0 counts as 1, capped at the table depth
  function automatic logic [SIZE_W-1:0] size_in_use(input logic [CFG_W-1:0] cfg);
    logic [31:0] s;
    s = 32'(cfg);
    if (s == 32'd0) s = 32'd1;
    if (s > 32'(TABLE_DEPTH)) s = 32'(TABLE_DEPTH);
    return SIZE_W'(s);
  endfunction

endpackage

FILE: design/stpc_front.sv
// ----------------------------------------------------------------------------
// stpc_front
// Accepts requests, clamps indices, screens centroid spans, feeds the queue.
// ----------------------------------------------------------------------------
module stpc_front (
  input  logic                         in_valid,
  output logic                         in_ready,
  input  stpc_pkg::stpc_in_t           in_data,
  input  logic [stpc_pkg::CFG_W-1:0]   table_size,
  input  logic                         back_ready,
  input  logic                         q_full,
  output stpc_pkg::stpc_push_t         push
);
  import stpc_pkg::*;

  logic [SIZE_W-1:0] sz;
  logic [31:0]       sz32;
  logic [IDX_W-1:0]  idx;
  logic              span_ok;

  assign sz   = size_in_use(table_size);
  assign sz32 = 32'(sz);

  always_comb begin
    if (in_data.index[31]) begin
      idx = '0;
    end else if ($unsigned(in_data.index) >= sz32) begin
      idx = IDX_W'(sz32 - 32'd1);
    end else begin
      idx = in_data.index[IDX_W-1:0];
    end
  end

  assign span_ok  = 32'(in_data.span_length) <= sz32;
  assign in_ready = back_ready && !q_full;

  always_comb begin
    push.op.req    = in_data.req_type;
    push.op.idx    = idx;
    push.op.sample = in_data.sample_in;
    push.op.span   = SIZE_W'(in_data.span_length);
    // an over-long centroid span is taken and dropped here
    push.push      = in_valid && in_ready &&
                     !(in_data.req_type == REQ_CENTROID && !span_ok);
  end

endmodule

FILE: design/stpc_queue.sv
// ----------------------------------------------------------------------------
// stpc_queue
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module stpc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  stpc_pkg::stpc_push_t  push,
  input  logic                  pop,
  output logic                  full,
  output stpc_pkg::stpc_head_t  head
);
  import stpc_pkg::*;

  stpc_op_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_pop;

  assign full       = cnt_r == QCNT_W'(QDEPTH);
  assign head.avail = cnt_r != '0;
  assign head.op    = slot_r[rp_r];
  assign do_pop     = pop && head.avail;

  always_ff @(posedge clk) begin
    if (push.push) begin
      slot_r[wp_r] <= push.op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push.push) wp_r <= QPTR_W'((32'(wp_r) + 1) % QDEPTH);
      if (do_pop)    rp_r <= QPTR_W'((32'(rp_r) + 1) % QDEPTH);
      if (push.push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push.push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: design/stpc_div.sv
// ----------------------------------------------------------------------------
// stpc_div
// Bit-serial signed divider: (256*num)/den, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
module stpc_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  stpc_pkg::stpc_div_req_t req,
  output stpc_pkg::stpc_div_rsp_t rsp
);
  import stpc_pkg::*;

  stpc_div_state_t         state_r, state_nxt;
  logic [DIV_W-1:0]        nq_r, nq_nxt;     // dividend shifting out, quotient in
  logic [BOT_W-1:0]        dm_r, dm_nxt;
  logic [BOT_W-1:0]        rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                    neg_r, neg_nxt;
  logic                    zero_r, zero_nxt;
  logic [TOP_W-1:0]        num_mag;
  logic [BOT_W:0]          rem_sh;
  logic                    ovf_pos, ovf_neg;
  logic [CEN_W-1:0]        sat_q;
  logic signed [CEN_W-1:0] hold_r;

  assign num_mag = req.num[TOP_W-1] ? TOP_W'(-req.num) : TOP_W'(req.num);
  assign rem_sh  = {rem_r, nq_r[DIV_W-1]};
  assign ovf_pos = |nq_r[DIV_W-1:CEN_W-1];
  assign ovf_neg = (|nq_r[DIV_W-1:CEN_W]) || (nq_r[CEN_W-1] && |nq_r[CEN_W-2:0]);

  assign rsp.done = state_r == DV_FIN;
  assign rsp.quo  = hold_r;

  always_comb begin
    state_nxt = state_r;
    nq_nxt    = nq_r;
    dm_nxt    = dm_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    zero_nxt  = zero_r;
    unique case (state_r)
      DV_IDLE: begin
        if (req.start) begin
          nq_nxt    = {num_mag, FRAC_W'(0)};
          dm_nxt    = req.den[BOT_W-1] ? BOT_W'(-req.den) : BOT_W'(req.den);
          rem_nxt   = '0;
          cnt_nxt   = DIV_CNT_W'(DIV_W);
          neg_nxt   = req.num[TOP_W-1] ^ req.den[BOT_W-1];
          zero_nxt  = req.den == '0;
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        if (rem_sh >= {1'b0, dm_r}) begin
          rem_nxt = BOT_W'(rem_sh - {1'b0, dm_r});
          nq_nxt  = {nq_r[DIV_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[BOT_W-1:0];
          nq_nxt  = {nq_r[DIV_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) state_nxt = DV_FIN;
      end
      DV_FIN: begin
        state_nxt = DV_IDLE;
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  // result word, formed in the cycle after the last step
  always_comb begin
    if (zero_r) begin
      sat_q = '0;
    end else if (!neg_r) begin
      sat_q = ovf_pos ? CEN_MAX : nq_r[CEN_W-1:0];
    end else begin
      sat_q = ovf_neg ? CEN_MIN : CEN_W'(-nq_r[CEN_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nq_r   <= nq_nxt;
    dm_r   <= dm_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    neg_r  <= neg_nxt;
    zero_r <= zero_nxt;
  end

  // hold the saturated quotient from the finish cycle on
  always_ff @(posedge clk) begin
    if (state_r == DV_FIN) begin
      hold_r <= sat_q;
    end
  end

endmodule

FILE: design/stpc_back.sv
// ----------------------------------------------------------------------------
// stpc_back
// Executes queued requests on the sample store; centroid walk and result.
// ----------------------------------------------------------------------------
module stpc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stpc_pkg::stpc_head_t     head,
  output logic                     pop,
  output logic                     ready,
  output stpc_pkg::stpc_div_req_t  div_req,
  input  stpc_pkg::stpc_div_rsp_t  div_rsp,
  output logic                     out_valid,
  input  logic                     out_ready,
  output stpc_pkg::stpc_out_t      out_data
);
  import stpc_pkg::*;

  logic [SAMPLE_W-1:0] mem [TABLE_DEPTH];
  logic                mem_we;
  logic [IDX_W-1:0]    mem_wa;
  logic [SAMPLE_W-1:0] mem_wd;
  logic [IDX_W-1:0]    rd_addr;
  logic signed [SAMPLE_W-1:0] rd_r;

  stpc_state_t               state_r, state_nxt;
  logic [SIZE_W-1:0]         cnt_r, cnt_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [SAMPLE_W-1:0]       pend_val_r, pend_val_nxt;
  logic                      pend_flag_r, pend_flag_nxt;
  logic [SIZE_W-1:0]         span_r, span_nxt;
  logic signed [TOP_W-1:0]   top_r, top_nxt;
  logic signed [BOT_W-1:0]   bot_r, bot_nxt;
  logic                      dv_r, dv_nxt;
  logic [IDX_W-1:0]          widx_r, widx_nxt;
  logic                      cen_r, cen_nxt;
  logic                      out_valid_r, out_valid_nxt;
  stpc_out_t                 out_data_r, out_data_nxt;
  logic signed [IDX_W+SAMPLE_W:0] prod;

  assign prod      = $signed({1'b0, widx_r}) * rd_r;
  assign ready     = state_r != ST_CLEAR;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign div_req.num = top_r;
  assign div_req.den = bot_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pend_val_nxt  = pend_val_r;
    pend_flag_nxt = pend_flag_r;
    span_nxt      = span_r;
    top_nxt       = top_r;
    bot_nxt       = bot_r;
    dv_nxt        = 1'b0;
    widx_nxt      = widx_r;
    cen_nxt       = cen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = cnt_r[IDX_W-1:0];
    mem_wd        = '0;
    rd_addr       = idx_r;
    pop           = 1'b0;
    div_req.start = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SIZE_W'(TABLE_DEPTH - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = head.op.idx;
        if (head.avail) begin
          pop = 1'b1;
          unique case (head.op.req)
            REQ_ARM: begin
              pend_val_nxt  = head.op.sample;
              pend_flag_nxt = 1'b1;
            end
            REQ_ACCESS: begin
              if (pend_flag_r) begin
                mem_we        = 1'b1;
                mem_wa        = head.op.idx;
                mem_wd        = pend_val_r;
                pend_flag_nxt = 1'b0;
              end else begin
                idx_nxt   = head.op.idx;
                cen_nxt   = 1'b0;
                state_nxt = ST_RESP;
              end
            end
            REQ_WRITE: begin
              mem_we        = 1'b1;
              mem_wa        = head.op.idx;
              mem_wd        = head.op.sample;
              pend_val_nxt  = head.op.sample;
              pend_flag_nxt = 1'b0;
            end
            REQ_CENTROID: begin
              span_nxt  = head.op.span;
              top_nxt   = '0;
              bot_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_WALK;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        // read issued one cycle, weighted and summed the next
        rd_addr = cnt_r[IDX_W-1:0];
        if (dv_r) begin
          top_nxt = top_r + TOP_W'(prod);
          bot_nxt = bot_r + BOT_W'(rd_r);
        end
        if (cnt_r < span_r) begin
          dv_nxt   = 1'b1;
          widx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt  = cnt_r + 1'b1;
        end else if (!dv_r) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          cen_nxt   = 1'b1;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          if (cen_r) begin
            out_data_nxt.result_kind  = KIND_CENTROID;
            out_data_nxt.sample_out   = '0;
            out_data_nxt.centroid_out = div_rsp.quo;
          end else begin
            out_data_nxt.result_kind  = KIND_SAMPLE;
            out_data_nxt.sample_out   = rd_r;
            out_data_nxt.centroid_out = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_val_r  <= '0;
      pend_flag_r <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_val_r  <= pend_val_nxt;
      pend_flag_r <= pend_flag_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    span_r     <= span_nxt;
    top_r      <= top_nxt;
    bot_r      <= bot_nxt;
    widx_r     <= widx_nxt;
    cen_r      <= cen_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: design/sample_table_poke_and_centroid.sv
// ----------------------------------------------------------------------------
// sample_table_poke_and_centroid
// Q1.15 sample table with armed (delayed) writes, reads and a centroid.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-entry sample store to zero, one
// entry a cycle, and holds in_ready low while it sweeps; cfg writes
// are taken throughout. A front stage then takes one request per cycle
// while the back end is ready and the queue is not full, clamps the
// index to 0..size-1, drops centroid requests whose span is longer than
// the size in use, and parks the rest in a two-entry queue. The back
// end works off that queue one request at a time on a single write port
// and a single registered read port of the store:
//   arm, write, and access with a pending value armed: taken in the idle
//     state, no result;
//   access without a pending value: read, registered data, output load;
//   centroid: a walk of the store over the span through the read port,
//     the bit-serial divider (one quotient bit per cycle over 45 bits,
//     then a finish step that saturates), then an output load.
// The result sits in an output register, so the front keeps filling the
// queue while a finished result waits for out_ready. table_size is read
// as it stands; change it only while no request is in flight.
// Centroid = trunc(256 * sum(i*s[i]) / sum(s[i])), saturated to 32 bits,
// 0 when the sample sum is zero.
// ----------------------------------------------------------------------------
module sample_table_poke_and_centroid (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  stpc_pkg::stpc_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output stpc_pkg::stpc_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [stpc_pkg::CFG_W-1:0]  cfg_wdata
);
  import stpc_pkg::*;

  logic [CFG_W-1:0] table_size_r;
  stpc_push_t       push;
  stpc_head_t       head;
  logic             q_full;
  logic             pop;
  logic             back_ready;
  stpc_div_req_t    div_req;
  stpc_div_rsp_t    div_rsp;

  // table size register, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= CFG_RESET;
    end else if (cfg_we) begin
      table_size_r <= cfg_wdata;
    end
  end

  // front: accept, clamp, screen
  stpc_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .table_size (table_size_r),
    .back_ready (back_ready),
    .q_full     (q_full),
    .push       (push)
  );

  // decoupling queue
  stpc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // back: store, pending write, centroid walk, output register
  stpc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .ready     (back_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // serial divider for the centroid
  stpc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

FILE: design/stpc_checker.sv
// ----------------------------------------------------------------------------
// stpc_checker
// Port-level checks on the sample table block, bound to the top level.
// ----------------------------------------------------------------------------
`include "sample_table_poke_and_centroid_assert.svh"

module stpc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  stpc_pkg::stpc_in_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  stpc_pkg::stpc_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [stpc_pkg::CFG_W-1:0]  cfg_wdata
);
  import stpc_pkg::*;

  logic unused_ok;
  assign unused_ok = in_valid ^ (|in_data) ^ cfg_we ^ (|cfg_wdata);

  `STPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result request dropped while stalled")
  `STPC_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "stalled result request changed")
  `STPC_ASSERT_RST(a_rst_no_out, !rst_n |=> !out_valid, "result request right after reset")
  `STPC_ASSERT_RST(a_rst_clear, !rst_n |=> !in_ready, "request taken during store clearing")
  `STPC_ASSERT(a_kind_fields, out_valid |-> (out_data.result_kind == KIND_CENTROID || out_data.centroid_out == '0) && (out_data.result_kind == KIND_SAMPLE || out_data.sample_out == '0), "unused result field not zero")

endmodule

bind sample_table_poke_and_centroid stpc_checker u_stpc_checker (.*);
